>>> rtl/caldate_pkg.sv
`timescale 1ns / 1ps

package caldate_pkg;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_t;

  // Operations of the shared date step unit
  localparam logic [1:0] STEP_DAY   = 2'd0;
  localparam logic [1:0] STEP_MONTH = 2'd1;
  localparam logic [1:0] STEP_YEAR  = 2'd2;

  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  localparam logic [15:0] YEAR_RESET   = 16'd1900;
  localparam logic [15:0] MAX_ADD_DAYS = 16'd1023;

  // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT for every 16-bit y
  localparam logic [17:0] DIV25_MUL   = 18'd167773;
  localparam int          DIV25_SHIFT = 22;
  localparam logic [4:0]  DIV25_DEN   = 5'd25;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/caldate_leap.sv
`timescale 1ns / 1ps

// Two-stage leap year check: multiply by the reciprocal of 25, then
// take the remainder and combine it with the low bits of the year.
module caldate_leap (
  input  logic        clk,
  input  logic [15:0] year,
  output logic        leap
);

  logic [33:0] prod;
  logic [15:0] year_s1;
  logic [11:0] quot;
  logic [16:0] diff;
  logic [4:0]  rem;
  logic        leap_next;

  always_ff @(posedge clk) begin
    prod    <= 34'(year) * 34'(caldate_pkg::DIV25_MUL);
    year_s1 <= year;
    leap    <= leap_next;
  end

  always_comb begin
    quot = 12'(prod >> caldate_pkg::DIV25_SHIFT);
    diff = {1'b0, year_s1} - 17'(quot * 17'(caldate_pkg::DIV25_DEN));
    rem  = diff[4:0];
    // divisible by 4 but not 100, or divisible by 400 (16 and 25)
    leap_next = ((year_s1[1:0] == 2'b00) && (rem != 5'd0)) ||
                ((year_s1[3:0] == 4'b0000) && (rem == 5'd0));
  end

endmodule

>>> rtl/caldate_step.sv
`timescale 1ns / 1ps

// Shared date step unit: advance the date by one day, month or year.
module caldate_step (
  input  caldate_pkg::date_t date_in,
  input  logic               leap,
  input  logic [1:0]         op,
  output caldate_pkg::date_t date_out,
  output logic               year_changed
);

  logic [5:0]  day_inc;
  logic        day_roll;
  logic        month_roll;
  logic [3:0]  month_inc;
  logic [15:0] year_inc;

  always_comb begin
    day_inc    = {1'b0, date_in.day} + 6'd1;
    day_roll   = day_inc > {1'b0, caldate_pkg::month_days(date_in.month, leap)};
    month_roll = date_in.month >= caldate_pkg::MONTH_DEC;
    month_inc  = month_roll ? caldate_pkg::MONTH_JAN : date_in.month + 4'd1;
    year_inc   = date_in.year + 16'd1;

    date_out     = date_in;
    year_changed = 1'b0;
    unique case (op)
      caldate_pkg::STEP_DAY: begin
        if (day_roll) begin
          date_out.day   = caldate_pkg::DAY_FIRST;
          date_out.month = month_inc;
          if (month_roll) begin
            date_out.year = year_inc;
            year_changed  = 1'b1;
          end
        end else begin
          date_out.day = day_inc[4:0];
        end
      end
      caldate_pkg::STEP_MONTH: begin
        date_out.month = month_inc;
        if (month_roll) begin
          date_out.year = year_inc;
          year_changed  = 1'b1;
        end
      end
      caldate_pkg::STEP_YEAR: begin
        date_out.year = year_inc;
        year_changed  = 1'b1;
      end
      default: begin
        date_out = date_in;
      end
    endcase
  end

endmodule

>>> rtl/calendar_date_counter_top.sv
`timescale 1ns / 1ps

// Gregorian calendar date counter.
// Slave channel s_*: one command request per handshake. s_tuser carries the
// action (set, next day, next month, next year, compare, add days), s_tdata
// the day, month and year arguments and the add count.
// Master channel m_*: one result per request, the stored date after the
// command and the compare flag (zero for every action but compare).
// Path through the sequencer: compare and unused actions go straight to the
// finish state, next day/month/year go through the step state, set waits in
// the argument state for the leap check on the set year, and add n days (n
// saturated at MAX_ADD_DAYS) walks one day per cycle through the shared step
// unit. Every step that changes the year stops in the leap state to rerun
// the two-stage leap check on the new year, which holds the walk meanwhile.
// One request is in flight at a time: s_tready is high only while the
// sequencer is idle, so a new request waits until the last one is finished.
// The result register parts the two channels: a new request is taken while
// the previous result still waits, and the sequencer holds its finished
// result until m_tready frees the register.
// Reset (rst, synchronous) loads 1 January 1900, clears any pending result
// and returns the sequencer to idle.
module calendar_date_counter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // arg_day[4:0], arg_month[8:5], arg_year[24:9],
                                // add_count[34:25], zero[39:35]
  input  logic [2:0]  s_tuser,  // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // cur_day[4:0], cur_month[8:5], cur_year[24:9],
                                // dates_equal[25], zero[31:26]
);

  localparam logic [2:0] ACT_SET    = 3'd0;
  localparam logic [2:0] ACT_NDAY   = 3'd1;
  localparam logic [2:0] ACT_NMONTH = 3'd2;
  localparam logic [2:0] ACT_NYEAR  = 3'd3;
  localparam logic [2:0] ACT_CMP    = 3'd4;
  localparam logic [2:0] ACT_ADD    = 3'd5;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_ARG    = 3'd2;
  localparam logic [2:0] S_LEAP   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [1:0] LEAP_WAIT = 2'd2;

  logic [2:0]         state;
  logic [1:0]         wait_cnt;
  logic [1:0]         cmd_op;
  logic [4:0]         cmd_day;
  logic [3:0]         cmd_month;
  logic [15:0]        cmd_year;
  logic [9:0]         cnt;
  logic               cmd_eq;
  caldate_pkg::date_t date;
  logic               leap_cur;

  caldate_pkg::date_t res_date;
  logic               res_eq;
  logic               res_valid;

  // request fields
  logic [2:0]  in_action;
  logic [4:0]  in_day;
  logic [3:0]  in_month;
  logic [15:0] in_year;
  logic [9:0]  in_count;
  logic [9:0]  sat_count;
  logic        accept;

  // shared units
  logic [15:0]        leap_year;
  logic               leap_out;
  caldate_pkg::date_t step_date;
  logic               step_year_changed;
  logic               arg_month_ok;
  logic               arg_day_ok;
  logic               res_free;

  assign in_action = s_tuser[2:0];
  assign in_day    = s_tdata[4:0];
  assign in_month  = s_tdata[8:5];
  assign in_year   = s_tdata[24:9];
  assign in_count  = s_tdata[34:25];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign res_free = !res_valid || m_tready;

  // saturate the add count
  assign sat_count = ({6'b0, in_count} > caldate_pkg::MAX_ADD_DAYS) ?
                     caldate_pkg::MAX_ADD_DAYS[9:0] : in_count;

  // the leap check looks at the set argument, otherwise at the stored year
  assign leap_year = (state == S_ARG) ? cmd_year : date.year;

  caldate_leap u_leap (
    .clk  (clk),
    .year (leap_year),
    .leap (leap_out)
  );

  caldate_step u_step (
    .date_in      (date),
    .leap         (leap_cur),
    .op           (cmd_op),
    .date_out     (step_date),
    .year_changed (step_year_changed)
  );

  assign arg_month_ok = (cmd_month >= caldate_pkg::MONTH_JAN) &&
                        (cmd_month <= caldate_pkg::MONTH_DEC);
  assign arg_day_ok   = (cmd_day != 5'd0) &&
                        (cmd_day <= caldate_pkg::month_days(cmd_month, leap_out));

  // command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_day   <= in_day;
      cmd_month <= in_month;
      cmd_year  <= in_year;
      cmd_eq    <= (in_action == ACT_CMP) && (in_day == date.day) &&
                   (in_month == date.month) && (in_year == date.year);
      unique case (in_action)
        ACT_NMONTH: cmd_op <= caldate_pkg::STEP_MONTH;
        ACT_NYEAR:  cmd_op <= caldate_pkg::STEP_YEAR;
        default:    cmd_op <= caldate_pkg::STEP_DAY;
      endcase
    end
  end

  // sequencer and date state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wait_cnt   <= 2'd0;
      cnt        <= 10'd0;
      date.day   <= caldate_pkg::DAY_FIRST;
      date.month <= caldate_pkg::MONTH_JAN;
      date.year  <= caldate_pkg::YEAR_RESET;
      leap_cur   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          wait_cnt <= 2'd0;
          if (accept) begin
            unique case (in_action)
              ACT_SET: begin
                state <= S_ARG;
              end
              ACT_NDAY, ACT_NMONTH, ACT_NYEAR: begin
                cnt   <= 10'd1;
                state <= S_STEP;
              end
              ACT_ADD: begin
                cnt   <= sat_count;
                state <= (sat_count != 10'd0) ? S_STEP : S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_STEP: begin
          // advance one step, stop for a leap recheck when the year moves
          date     <= step_date;
          cnt      <= cnt - 10'd1;
          wait_cnt <= 2'd0;
          if (step_year_changed) begin
            state <= S_LEAP;
          end else if (cnt == 10'd1) begin
            state <= S_FINISH;
          end
        end
        S_ARG: begin
          wait_cnt <= wait_cnt + 2'd1;
          if (wait_cnt == LEAP_WAIT) begin
            if (arg_month_ok) begin
              date.month <= cmd_month;
              if (arg_day_ok) begin
                date.day  <= cmd_day;
                date.year <= cmd_year;
                leap_cur  <= leap_out;
              end
            end
            state <= S_FINISH;
          end
        end
        S_LEAP: begin
          wait_cnt <= wait_cnt + 2'd1;
          if (wait_cnt == LEAP_WAIT) begin
            leap_cur <= leap_out;
            state    <= (cnt != 10'd0) ? S_STEP : S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the result register is free
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FINISH && res_free) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && res_free) begin
      res_date <= date;
      res_eq   <= cmd_eq;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {6'b0, res_eq, res_date.year, res_date.month, res_date.day};

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while a command is in flight");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (date.month >= caldate_pkg::MONTH_JAN) && (date.month <= caldate_pkg::MONTH_DEC))
    else $error("stored month out of range");

  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    date.day != 5'd0)
    else $error("stored day is zero");

  a_leap_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && date.year[1:0] != 2'b00) |-> !leap_cur)
    else $error("stale leap flag for the stored year");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_free) |=> m_tvalid)
    else $error("finished command did not present a result");
`endif

endmodule

>>> test/calendar_date_checker.sv
`timescale 1ns / 1ps

package caldate_test_pkg;
  import caldate_pkg::*;

  typedef enum logic [2:0] {
    ACT_SET        = 3'd0,
    ACT_NEXT_DAY   = 3'd1,
    ACT_NEXT_MONTH = 3'd2,
    ACT_NEXT_YEAR  = 3'd3,
    ACT_COMPARE    = 3'd4,
    ACT_ADD_DAYS   = 3'd5,
    ACT_SPARE_A    = 3'd6,
    ACT_SPARE_B    = 3'd7
  } cal_action_e;

  typedef struct packed {
    date_t date;
    logic  same;
  } cal_result_t;

  function automatic bit leap_year(input logic [15:0] y);
    return ((y % 16'd4 == 0) && (y % 16'd100 != 0)) || (y % 16'd400 == 0);
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [15:0] y);
    case (m)
      MONTH_FEB:                return leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                  return 5'd31;
    endcase
  endfunction

endpackage

module calendar_date_checker
  import caldate_pkg::*;
  import caldate_test_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          checked,
  output date_t       model_date
);

  cal_result_t expected_dates[$];

  function automatic date_t bump_year(input date_t d);
    d.year = d.year + 16'd1;
    return d;
  endfunction

  function automatic date_t bump_month(input date_t d);
    if (d.month >= MONTH_DEC) begin
      d.month = MONTH_JAN;
      d = bump_year(d);
    end else begin
      d.month = d.month + 4'd1;
    end
    return d;
  endfunction

  // day is never clamped on a month step, so it may already exceed the month
  function automatic date_t bump_day(input date_t d);
    if (int'(d.day) + 1 > int'(days_in_month(d.month, d.year))) begin
      d.day = DAY_FIRST;
      d = bump_month(d);
    end else begin
      d.day = d.day + 5'd1;
    end
    return d;
  endfunction

  function automatic cal_result_t apply_command(input date_t cur, input cal_action_e act,
                                                input logic [39:0] args);
    cal_result_t r;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [15:0] y;
    int unsigned n;
    d = args[4:0];
    m = args[8:5];
    y = args[24:9];
    n = 32'(args[34:25]);
    r.date = cur;
    r.same = 1'b0;
    case (act)
      ACT_SET: begin
        if (m >= MONTH_JAN && m <= MONTH_DEC) begin
          r.date.month = m;
          if (d != 5'd0 && d <= days_in_month(m, y)) begin
            r.date.day  = d;
            r.date.year = y;
          end
        end
      end
      ACT_NEXT_DAY:   r.date = bump_day(cur);
      ACT_NEXT_MONTH: r.date = bump_month(cur);
      ACT_NEXT_YEAR:  r.date = bump_year(cur);
      ACT_COMPARE:    r.same = (d == cur.day) && (m == cur.month) && (y == cur.year);
      ACT_ADD_DAYS: begin
        if (n > 32'(MAX_ADD_DAYS)) n = 32'(MAX_ADD_DAYS);
        for (int i = 0; i < n; i++) r.date = bump_day(r.date);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (errors < 40)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  initial begin
    errors  = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    cal_result_t want;
    if (rst) begin
      model_date <= '{day: DAY_FIRST, month: MONTH_JAN, year: YEAR_RESET};
      expected_dates.delete();
      pending <= 0;
    end else begin
      // results first, so a request taken on the same edge cannot cover a stray result
      if (m_tvalid && m_tready) begin
        if (expected_dates.size() == 0) begin
          if (errors < 40)
            $display("%0t: result with nothing expected, got %0d/%0d/%0d flag %0d", $time,
                     m_tdata[4:0], m_tdata[8:5], m_tdata[24:9], m_tdata[25]);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          if (m_tdata[4:0] !== want.date.day)    report_field("day", want.date.day, m_tdata[4:0]);
          if (m_tdata[8:5] !== want.date.month)  report_field("month", want.date.month,
                                                              m_tdata[8:5]);
          if (m_tdata[24:9] !== want.date.year)  report_field("year", want.date.year,
                                                              m_tdata[24:9]);
          if (m_tdata[25] !== want.same)         report_field("dates_equal", want.same,
                                                              m_tdata[25]);
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_command(model_date, cal_action_e'(s_tuser), s_tdata);
        expected_dates.push_back(want);
        model_date <= want.date;
      end
      pending <= expected_dates.size();
    end
  end

endmodule

>>> test/calendar_date_counter_top_test.sv
`timescale 1ns / 1ps

module calendar_date_counter_top_test;
  import caldate_pkg::*;
  import caldate_test_pkg::*;

  // Where the date arguments of a request come from: as given, the stored
  // date, or the stored date with one bit flipped.
  typedef enum int {ARGS_GIVEN, ARGS_CURRENT, ARGS_NEAR} arg_source_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // arg_day[4:0], arg_month[8:5], arg_year[24:9],
                               // add_count[34:25], zero[39:35]
  logic [2:0]  s_tuser = '0;   // action[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // cur_day[4:0], cur_month[8:5], cur_year[24:9],
                               // dates_equal[25], zero[31:26]

  int    errors;
  int    pending;
  int    checked;
  date_t model_date;

  int    n_sent = 0;
  int    action_count[8];
  bit    quiet = 1'b0;       // no random gaps and no new stalls while set
  int    stall_left = 0;

  calendar_date_counter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  calendar_date_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .model_date (model_date)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; a clean run ends far earlier.
  initial begin
    #30_000_000;
    $display("Timeout: %0d requests sent, %0d results still expected", n_sent, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet)  return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Keep most additions short; a few walk the full count range.
  function automatic logic [9:0] pick_add_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 10'($urandom_range(0, 40));
    if (r < 95) return 10'($urandom_range(41, 300));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Favor century and leap-rule corners and the wrap at the top of the year range.
  function automatic logic [15:0] pick_year();
    case ($urandom_range(0, 7))
      0:       return 16'(1600 + 100 * $urandom_range(0, 9));
      1:       return 16'($urandom_range(1970, 2100));
      2:       return 16'(4 * $urandom_range(0, 16383));
      3:       return 16'($urandom_range(65530, 65535));
      4:       return 16'($urandom_range(0, 3));
      5:       return 16'(400 * $urandom_range(0, 163));
      default: return 16'($urandom);
    endcase
  endfunction

  // Lean toward the last days of the month, where the rollovers live.
  function automatic logic [4:0] pick_day(input logic [3:0] m, input logic [15:0] y);
    int len;
    len = int'(days_in_month(m, y));
    if ($urandom_range(0, 9) < 6) return 5'($urandom_range(len - 2, len));
    return 5'($urandom_range(1, len));
  endfunction

  // Receiver side: stall at random, hold ready during quiet stretches once a running stall ends.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      m_tready <= 1'b0;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70)
                                                : $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Present one request and hold it until the block takes it. Valid stays
  // high on return so back-to-back requests need no extra edge.
  task automatic send_request(input cal_action_e act, input logic [4:0] d,
                              input logic [3:0] m, input logic [15:0] y,
                              input logic [9:0] n, input arg_source_e src);
    int gap;
    gap = pick_gap();
    // the model's stored date is registered at the last handshake; let it settle
    if (src != ARGS_GIVEN && gap == 0) gap = 1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 40'({$urandom, $urandom});
      s_tuser  <= 3'($urandom);
      repeat (gap) @(posedge clk);
    end
    if (src != ARGS_GIVEN) begin
      d = model_date.day;
      m = model_date.month;
      y = model_date.year;
    end
    if (src == ARGS_NEAR) begin
      case ($urandom_range(0, 2))
        0:       d ^= 5'(1 << $urandom_range(0, 4));
        1:       m ^= 4'(1 << $urandom_range(0, 3));
        default: y ^= 16'(1 << $urandom_range(0, 15));
      endcase
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'd0, n, y, m, d};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    action_count[act]++;
  endtask

  // Drop valid and hold off until every outstanding result is back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [4:0]  d;
    logic [3:0]  m;
    logic [15:0] y;
    int          next_drain;
    int          r;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset date, ignored and partial sets, leap rule,
    // rollovers, unclamped day after a month step, year wrap, add extremes.
    send_request(ACT_COMPARE,    5'd1,  4'd1,  16'd1900,  10'd0,    ARGS_GIVEN);
    send_request(ACT_COMPARE,    5'd31, 4'd15, 16'd65535, 10'd1023, ARGS_GIVEN);
    send_request(ACT_SET,        5'd10, 4'd0,  16'd2020,  10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd10, 4'd13, 16'd2020,  10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd0,  4'd5,  16'd2000,  10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd31, 4'd4,  16'd1999,  10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd29, 4'd2,  16'd1900,  10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd29, 4'd2,  16'd2100,  10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd29, 4'd2,  16'd2000,  10'd0,    ARGS_GIVEN);
    send_request(ACT_NEXT_DAY,   5'd0,  4'd0,  16'd0,     10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd28, 4'd2,  16'd1900,  10'd0,    ARGS_GIVEN);
    send_request(ACT_NEXT_DAY,   5'd0,  4'd0,  16'd0,     10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd31, 4'd1,  16'd2023,  10'd0,    ARGS_GIVEN);
    send_request(ACT_NEXT_MONTH, 5'd0,  4'd0,  16'd0,     10'd0,    ARGS_GIVEN);
    send_request(ACT_NEXT_DAY,   5'd0,  4'd0,  16'd0,     10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd31, 4'd12, 16'd65535, 10'd0,    ARGS_GIVEN);
    send_request(ACT_NEXT_DAY,   5'd0,  4'd0,  16'd0,     10'd0,    ARGS_GIVEN);
    send_request(ACT_SET,        5'd29, 4'd2,  16'd0,     10'd0,    ARGS_GIVEN);
    send_request(ACT_COMPARE,    5'd0,  4'd0,  16'd0,     10'd0,    ARGS_CURRENT);
    send_request(ACT_SET,        5'd15, 4'd6,  16'd65535, 10'd0,    ARGS_GIVEN);
    send_request(ACT_NEXT_YEAR,  5'd0,  4'd0,  16'd0,     10'd0,    ARGS_GIVEN);
    send_request(ACT_ADD_DAYS,   5'd0,  4'd0,  16'd0,     10'd1023, ARGS_GIVEN);
    send_request(ACT_ADD_DAYS,   5'd31, 4'd15, 16'd65535, 10'd0,    ARGS_GIVEN);
    send_request(ACT_SPARE_A,    5'd31, 4'd15, 16'd65535, 10'd1023, ARGS_GIVEN);
    send_request(ACT_SPARE_B,    5'd0,  4'd0,  16'd0,     10'd0,    ARGS_GIVEN);
    drain_results();

    // Random part: mostly set-walk-compare sequences, the rest raw noise.
    next_drain = n_sent + 120;
    while (n_sent < 580) begin
      quiet = ((n_sent % 150) < 25);
      if ($urandom_range(0, 9) < 3) begin
        send_request(cal_action_e'($urandom_range(0, 7)), 5'($urandom), 4'($urandom),
                     16'($urandom), pick_add_count(), ARGS_GIVEN);
      end else begin
        y = pick_year();
        m = 4'($urandom_range(1, 12));
        d = pick_day(m, y);
        send_request(ACT_SET, d, m, y, 10'($urandom), ARGS_GIVEN);
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 99);
          if (r < 40)      send_request(ACT_NEXT_DAY, 5'($urandom), 4'($urandom),
                                        16'($urandom), 10'($urandom), ARGS_GIVEN);
          else if (r < 55) send_request(ACT_NEXT_MONTH, 5'($urandom), 4'($urandom),
                                        16'($urandom), 10'($urandom), ARGS_GIVEN);
          else if (r < 70) send_request(ACT_NEXT_YEAR, 5'($urandom), 4'($urandom),
                                        16'($urandom), 10'($urandom), ARGS_GIVEN);
          else if (r < 90) send_request(ACT_ADD_DAYS, 5'($urandom), 4'($urandom),
                                        16'($urandom), pick_add_count(), ARGS_GIVEN);
          else             send_request(ACT_COMPARE, 5'd0, 4'd0, 16'd0,
                                        10'($urandom), ARGS_CURRENT);
        end
        send_request(ACT_COMPARE, 5'd0, 4'd0, 16'd0, 10'($urandom),
                     ($urandom_range(0, 9) < 6) ? ARGS_CURRENT : ARGS_NEAR);
      end
      if (n_sent >= next_drain) begin
        drain_results();
        next_drain += 120;
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (40) @(posedge clk);

    $display("Requests: %0d set, %0d next day, %0d next month, %0d next year, %0d compare,",
             action_count[ACT_SET], action_count[ACT_NEXT_DAY], action_count[ACT_NEXT_MONTH],
             action_count[ACT_NEXT_YEAR], action_count[ACT_COMPARE]);
    $display("  %0d add days, %0d unused codes; %0d results checked, %0d errors",
             action_count[ACT_ADD_DAYS], action_count[ACT_SPARE_A] + action_count[ACT_SPARE_B],
             checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
